// ===== rtl/quad_dac_slew_ramp_top_macros.svh =====
// assertion macros for the quad dac slew ramp checker
// depends on clk and arst_n being visible where a macro is used
`ifndef QUAD_DAC_SLEW_RAMP_TOP_MACROS_SVH
`define QUAD_DAC_SLEW_RAMP_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define QDSR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qdsr check failed");

// consequent checked in the cycle after the antecedent
`define QDSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qdsr check failed");

`endif

// ===== rtl/qdsr_pkg.sv =====
// shared types and constants for the quad dac slew ramp
// no dependencies
package qdsr_pkg;

	localparam int CHANNELS = 4;
	localparam int OUT_CH   = 4;

	localparam int LEVEL_W  = 14;
	localparam int FRAC_W   = 16;
	localparam int ACC_W    = 32;
	localparam int STEP_W   = 16;
	localparam int OFFS_W   = 15;
	localparam int CODE_W   = 12;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DVD_W    = LEVEL_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

	// command codes
	localparam logic [1:0] FUNC_SET_RAMP = 2'd0;
	localparam logic [1:0] FUNC_SET_NOW  = 2'd1;
	localparam logic [1:0] FUNC_TICK     = 2'd2;

	// first offset register index, slew lengths sit below it
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BASE = 3'd4;

	typedef struct packed {
		logic [1:0]         func;
		logic [1:0]         channel;
		logic [LEVEL_W-1:0] level_value;
	} cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_ch0;
		logic [CODE_W-1:0] code_ch1;
		logic [CODE_W-1:0] code_ch2;
		logic [CODE_W-1:0] code_ch3;
		logic [OUT_CH-1:0] slewing_mask;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_DIFF,
		ST_ABS,
		ST_DIV,
		ST_NEG,
		ST_TICK,
		ST_EMIT
	} seq_state_t;

	function automatic logic ch_present(input logic [1:0] idx);
		return int'(idx) < CHANNELS;
	endfunction

endpackage

// ===== rtl/quad_dac_slew_ramp_top.sv =====
// quad dac slew ramp: four channel level ramp with a shared 33-bit adder
// under a small sequencer; depends on qdsr_pkg
//
// channel | handshake             | payload
// cmd     | cmd_valid / cmd_ready | cmd (func, channel, level_value)
// res     | res_valid / res_ready | res (code_ch0..3, slewing_mask)
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one shared adder does the clamp sum, the ramp difference, every step of a
// 30-step restoring divider and the per-channel accumulate of a tick
// immediate set: clamp state only; ramped set: clamp, difference, absolute
// value, the divider steps and negation; tick: the four channel slots, then
// emit when a channel was active; an unused func code goes back to idle
// a tick result waits in the output register; the emit slot stalls only
// while an earlier result has not been taken
// arst_n clears all channel state to zero levels with one step left
module quad_dac_slew_ramp_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  qdsr_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output qdsr_pkg::res_t res,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [qdsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qdsr_pkg::CFG_W-1:0]     cfg_data
);
	import qdsr_pkg::*;

	// configuration registers
	logic [STEP_W-1:0] slew_q [OUT_CH];
	logic [OFFS_W-1:0] offs_q [OUT_CH];

	// per channel ramp state
	logic [LEVEL_W-1:0] target_q  [OUT_CH];
	logic [LEVEL_W-1:0] current_q [OUT_CH];
	logic [STEP_W-1:0]  steps_q   [OUT_CH];
	logic [ACC_W-1:0]   inc_q     [OUT_CH];
	logic [ACC_W-1:0]   acc_q     [OUT_CH];
	logic [OUT_CH-1:0]  slewing_q;

	// sequencer
	seq_state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [1:0]           tick_idx_q;
	logic                 any_q;

	// working registers of the current command
	cmd_t               cmd_q;
	logic [LEVEL_W-1:0] t_q;
	logic [LEVEL_W:0]   diff_q;
	logic               neg_q;
	logic [STEP_W-1:0]  n_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [STEP_W-1:0]  rem_q;

	// output register
	logic res_valid_q;
	res_t res_q;

	// shared adder
	logic [ACC_W-1:0] alu_a, alu_b;
	logic             alu_sub;
	logic [ACC_W:0]   alu_sum;

	assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {{ACC_W{1'b0}}, alu_sub};

	// decoded helpers
	logic [1:0]         ch;
	logic [LEVEL_W-1:0] t_clamped;
	logic               sum_neg, sum_over;
	logic [STEP_W-1:0]  n_eff;
	logic [STEP_W:0]    rem_sh;
	logic               div_ge;
	logic [LEVEL_W-1:0] mag;
	logic [1:0]         tc;
	logic               tick_act;
	logic [STEP_W-1:0]  steps_dec;
	logic               tick_last;
	logic               emit_go;

	assign ch        = cmd_q.channel;
	assign sum_neg   = alu_sum[ACC_W-1];
	assign sum_over  = !sum_neg && (|alu_sum[ACC_W-2:LEVEL_W]);
	assign t_clamped = sum_neg ? '0 : (sum_over ? LEVEL_MAX : alu_sum[LEVEL_W-1:0]);
	// a slew length of zero behaves as one
	assign n_eff     = (slew_q[ch] == '0) ? STEP_W'(1) : slew_q[ch];
	assign rem_sh    = {rem_q, dvd_q[DVD_W-1]};
	assign div_ge    = alu_sum[ACC_W];
	assign mag       = neg_q ? alu_sum[LEVEL_W-1:0] : diff_q[LEVEL_W-1:0];
	assign tc        = tick_idx_q;
	assign tick_act  = ch_present(tc) && (steps_q[tc] != '0);
	assign steps_dec = steps_q[tc] - STEP_W'(1);
	assign tick_last = (tick_idx_q == 2'(OUT_CH - 1));
	assign emit_go   = !res_valid_q || res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and shared adder operands
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		alu_a     = '0;
		alu_b     = '0;
		alu_sub   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					priority if (cmd.func == FUNC_SET_RAMP || cmd.func == FUNC_SET_NOW)
						state_d = ST_CLAMP;
					else if (cmd.func == FUNC_TICK)
						state_d = ST_TICK;
					else
						state_d = ST_IDLE;
				end
			end
			ST_CLAMP: begin
				// level plus signed offset
				alu_a = {{(ACC_W-LEVEL_W){1'b0}}, cmd_q.level_value};
				alu_b = {{(ACC_W-OFFS_W){offs_q[ch][OFFS_W-1]}}, offs_q[ch]};
				if (!ch_present(ch))
					state_d = ST_IDLE;
				else if (cmd_q.func == FUNC_SET_NOW)
					state_d = ST_IDLE;
				else
					state_d = ST_DIFF;
			end
			ST_DIFF: begin
				alu_a   = {{(ACC_W-LEVEL_W){1'b0}}, t_q};
				alu_b   = {{(ACC_W-LEVEL_W){1'b0}}, current_q[ch]};
				alu_sub = 1'b1;
				state_d = ST_ABS;
			end
			ST_ABS: begin
				alu_b   = {{(ACC_W-LEVEL_W-1){diff_q[LEVEL_W]}}, diff_q};
				alu_sub = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				// trial subtract of the divisor
				alu_a   = {{(ACC_W-STEP_W-1){1'b0}}, rem_sh};
				alu_b   = {{(ACC_W-STEP_W){1'b0}}, n_q};
				alu_sub = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DVD_W - 1))
					state_d = ST_NEG;
			end
			ST_NEG: begin
				alu_b   = {{(ACC_W-DVD_W){1'b0}}, dvd_q};
				alu_sub = 1'b1;
				state_d = ST_IDLE;
			end
			ST_TICK: begin
				alu_a = acc_q[tc];
				alu_b = inc_q[tc];
				if (tick_last)
					state_d = (any_q || tick_act) ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (emit_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OUT_CH; i++) begin
				slew_q[i] <= STEP_W'(1);
				offs_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < CFG_OFFSET_BASE)
				slew_q[cfg_index[1:0]] <= cfg_data;
			else
				offs_q[cfg_index[1:0]] <= cfg_data[OFFS_W-1:0];
		end
	end

	// channel state and sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OUT_CH; i++) begin
				target_q[i]  <= '0;
				current_q[i] <= '0;
				steps_q[i]   <= STEP_W'(1);
				inc_q[i]     <= '0;
				acc_q[i]     <= '0;
			end
			slewing_q  <= '0;
			div_cnt_q  <= '0;
			tick_idx_q <= '0;
			any_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					tick_idx_q <= '0;
					any_q      <= 1'b0;
					div_cnt_q  <= '0;
				end
				ST_CLAMP: begin
					if (ch_present(ch)) begin
						target_q[ch] <= t_clamped;
						if (cmd_q.func == FUNC_SET_NOW) begin
							steps_q[ch]   <= STEP_W'(1);
							current_q[ch] <= t_clamped;
							acc_q[ch]     <= {{(ACC_W-DVD_W){1'b0}}, t_clamped, {FRAC_W{1'b0}}};
						end else begin
							steps_q[ch] <= n_eff;
							acc_q[ch]   <= {{(ACC_W-DVD_W){1'b0}}, current_q[ch], {FRAC_W{1'b0}}};
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				end
				ST_NEG: begin
					// quotient truncated toward zero
					inc_q[ch] <= neg_q ? alu_sum[ACC_W-1:0] : {{(ACC_W-DVD_W){1'b0}}, dvd_q};
				end
				ST_TICK: begin
					if (tick_act) begin
						steps_q[tc] <= steps_dec;
						any_q       <= 1'b1;
						if (steps_dec == '0) begin
							current_q[tc] <= target_q[tc];
							slewing_q[tc] <= 1'b0;
						end else begin
							acc_q[tc]     <= alu_sum[ACC_W-1:0];
							current_q[tc] <= alu_sum[FRAC_W+LEVEL_W-1:FRAC_W];
							slewing_q[tc] <= 1'b1;
						end
					end
					tick_idx_q <= tick_idx_q + 2'd1;
				end
				ST_DIFF, ST_ABS, ST_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// working registers of the command in flight
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready)
			cmd_q <= cmd;
		unique case (state_q)
			ST_CLAMP: begin
				t_q <= t_clamped;
				n_q <= n_eff;
			end
			ST_DIFF: begin
				diff_q <= alu_sum[LEVEL_W:0];
				neg_q  <= alu_sum[ACC_W-1];
			end
			ST_ABS: begin
				dvd_q <= {mag, {FRAC_W{1'b0}}};
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? alu_sum[STEP_W-1:0] : rem_sh[STEP_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
			end
			ST_IDLE, ST_NEG, ST_TICK, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// output register, loaded once the previous result has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && emit_go) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_go) begin
			res_q.code_ch0 <= ch_present(2'd0) ? current_q[0][LEVEL_W-1:2] : '0;
			res_q.code_ch1 <= ch_present(2'd1) ? current_q[1][LEVEL_W-1:2] : '0;
			res_q.code_ch2 <= ch_present(2'd2) ? current_q[2][LEVEL_W-1:2] : '0;
			res_q.code_ch3 <= ch_present(2'd3) ? current_q[3][LEVEL_W-1:2] : '0;
			for (int i = 0; i < OUT_CH; i++)
				res_q.slewing_mask[i] <= ch_present(2'(i)) && slewing_q[i];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/qdsr_checker.sv =====
// port-level checks for the quad dac slew ramp, bound to the top level
// depends on qdsr_pkg and quad_dac_slew_ramp_top_macros.svh
`include "quad_dac_slew_ramp_top_macros.svh"

module qdsr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input qdsr_pkg::cmd_t cmd,
	input logic           res_valid,
	input logic           res_ready,
	input qdsr_pkg::res_t res
);
	import qdsr_pkg::*;

	// a set or tick always leaves the sequencer busy in the cycle after its transfer
	`QDSR_ASSERT_NEXT(a_busy_after_work, cmd_valid && cmd_ready && (cmd.func == FUNC_SET_RAMP || cmd.func == FUNC_SET_NOW || cmd.func == FUNC_TICK), !cmd_ready)

	// a new result only follows a busy cycle
	`QDSR_ASSERT_SAME(a_res_after_busy, $rose(res_valid), !$past(cmd_ready))

	// a stalled result holds
	`QDSR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

endmodule

bind quad_dac_slew_ramp_top qdsr_checker u_qdsr_checker (.*);

// ===== sim/tb_quad_dac_slew_ramp_top.sv =====
// self-checking bench for the quad dac slew ramp: directed and random commands,
// predicted codes and slewing masks compared per field against each result
// depends on qdsr_pkg and quad_dac_slew_ramp_top
module tb_quad_dac_slew_ramp_top;
	import qdsr_pkg::*;

	// func code the block ignores
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// slew length registers start at index zero
	localparam logic [CFG_IDX_W-1:0] CFG_SLEW_BASE = 3'd0;
	// a ramped set keeps the block busy after its transfer until its division is done
	localparam int SETTLE_CYCLES = 64;
	// longest quiet stretch of a correct run is the settle pause plus one set
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	quad_dac_slew_ramp_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predicted state of the block: configuration and per-channel ramps
	// ------------------------------------------------------------------
	logic [STEP_W-1:0]        slew_len   [CHANNELS];
	logic signed [OFFS_W-1:0] offset_reg [CHANNELS];
	logic [LEVEL_W-1:0]       target_lvl [CHANNELS];
	logic [LEVEL_W-1:0]       level_now  [CHANNELS];
	logic [STEP_W-1:0]        steps_left [CHANNELS];
	logic [ACC_W-1:0]         ramp_step  [CHANNELS];
	logic [ACC_W-1:0]         ramp_acc   [CHANNELS];
	logic                     ramping    [CHANNELS];

	cmd_t cmd_pending[$];
	res_t expected_codes[$];
	int   error_count = 0;
	bit   calm = 1'b0;

	// apply one accepted command to the predicted state; a tick that finds
	// any channel with steps left yields one expected frame
	function automatic void advance_levels(input cmd_t c);
		int   sum;
		int   diff;
		int   span;
		int   quot;
		int   active;
		int   i;
		res_t frame;
		logic [1:0] ch;
		ch = c.channel;
		case (c.func)
			FUNC_SET_RAMP, FUNC_SET_NOW: begin
				// offset first, then clamp into the 14-bit range
				sum = int'(c.level_value) + int'(offset_reg[ch]);
				if (sum < 0)
					sum = 0;
				else if (sum > int'(LEVEL_MAX))
					sum = int'(LEVEL_MAX);
				target_lvl[ch] = sum[LEVEL_W-1:0];
				if (c.func == FUNC_SET_NOW) begin
					steps_left[ch] = STEP_W'(1);
					level_now[ch]  = sum[LEVEL_W-1:0];
				end else begin
					// a zero slew length behaves as one tick
					span = int'(slew_len[ch]);
					if (span == 0)
						span = 1;
					steps_left[ch] = span[STEP_W-1:0];
					diff = int'(target_lvl[ch]) - int'(level_now[ch]);
					// signed division truncates toward zero
					quot = (diff * 65536) / span;
					ramp_step[ch] = quot;
				end
				ramp_acc[ch] = ACC_W'(level_now[ch]) << FRAC_W;
			end
			FUNC_TICK: begin
				active = 0;
				for (i = 0; i < CHANNELS; i++) begin
					if (steps_left[i] != 0) begin
						steps_left[i] = steps_left[i] - 1'b1;
						ramping[i] = 1'b0;
						if (steps_left[i] == 0) begin
							// last step lands exactly on the target
							level_now[i] = target_lvl[i];
						end else begin
							// accumulator wraps at 32 bits
							ramp_acc[i]  = ramp_acc[i] + ramp_step[i];
							level_now[i] = ramp_acc[i][FRAC_W +: LEVEL_W];
							ramping[i]   = 1'b1;
						end
						active++;
					end
				end
				if (active != 0) begin
					frame.code_ch0 = level_now[0][LEVEL_W-1:2];
					frame.code_ch1 = level_now[1][LEVEL_W-1:2];
					frame.code_ch2 = level_now[2][LEVEL_W-1:2];
					frame.code_ch3 = level_now[3][LEVEL_W-1:2];
					frame.slewing_mask = {ramping[3], ramping[2], ramping[1], ramping[0]};
					expected_codes.push_back(frame);
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// command driver: feeds the block from cmd_pending, idles in bursts
	// ------------------------------------------------------------------
	int cmd_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			// predict on the transfer itself, payload still holds the item
			if (cmd_valid && cmd_ready)
				advance_levels(cmd);
			if (!cmd_valid || cmd_ready) begin
				if (cmd_gap > 0) begin
					cmd_gap--;
					cmd_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					// start a burst of idle cycles, this one included
					cmd_gap = $urandom_range(0, 8);
					cmd_valid <= 1'b0;
				end else if (cmd_pending.size() != 0) begin
					cmd <= cmd_pending.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor: compares each transfer with the oldest prediction
	// and stalls res_ready in bursts
	// ------------------------------------------------------------------
	int   res_stall = 0;
	res_t want;

	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, res);
				error_count++;
			end else begin
				want = expected_codes.pop_front();
				if (res.code_ch0 !== want.code_ch0) begin
					$display("%0t: code_ch0 expected %0d got %0d", $time,
						want.code_ch0, res.code_ch0);
					error_count++;
				end
				if (res.code_ch1 !== want.code_ch1) begin
					$display("%0t: code_ch1 expected %0d got %0d", $time,
						want.code_ch1, res.code_ch1);
					error_count++;
				end
				if (res.code_ch2 !== want.code_ch2) begin
					$display("%0t: code_ch2 expected %0d got %0d", $time,
						want.code_ch2, res.code_ch2);
					error_count++;
				end
				if (res.code_ch3 !== want.code_ch3) begin
					$display("%0t: code_ch3 expected %0d got %0d", $time,
						want.code_ch3, res.code_ch3);
					error_count++;
				end
				if (res.slewing_mask !== want.slewing_mask) begin
					$display("%0t: slewing_mask expected %b got %b", $time,
						want.slewing_mask, res.slewing_mask);
					error_count++;
				end
			end
		end
		if (res_stall > 0) begin
			res_stall--;
			res_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			res_stall = $urandom_range(0, 8);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any transfer ends the run
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb_quad_dac_slew_ramp_top NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_cmd(input logic [1:0] f, input logic [1:0] ch,
		input logic [LEVEL_W-1:0] lvl);
		cmd_t c;
		c.func = f;
		c.channel = ch;
		c.level_value = lvl;
		cmd_pending.push_back(c);
	endtask

	// register write, only ever issued while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx < CFG_OFFSET_BASE)
			slew_len[idx[1:0]] = data;
		else
			offset_reg[idx[1:0]] = data[OFFS_W-1:0];
	endtask

	// wait until every command has gone in and every frame has come out,
	// then give a trailing set time to finish its division
	task automatic wait_quiet();
		do @(posedge clk);
		while (cmd_pending.size() != 0 || cmd_valid || expected_codes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return LEVEL_MAX;
			default: return LEVEL_W'($urandom);
		endcase
	endfunction

	// mostly short ramps so they finish, now and then zero or the longest
	function automatic logic [CFG_W-1:0] pick_slew();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3, 4: return CFG_W'($urandom_range(2, 8));
			default: return CFG_W'($urandom_range(1, 30));
		endcase
	endfunction

	// offset in the low 15 bits, top bit of the data word is don't-care
	function automatic logic [CFG_W-1:0] pick_offset();
		logic [OFFS_W-1:0] off;
		case ($urandom_range(0, 7))
			0: off = 15'h4000;
			1: off = 15'h3FFF;
			2: off = '0;
			3, 4, 5: off = OFFS_W'(int'($urandom_range(0, 2000)) - 1000);
			default: off = OFFS_W'($urandom);
		endcase
		return {1'($urandom), off};
	endfunction

	task automatic set_random_config();
		int i;
		for (i = 0; i < CHANNELS; i++)
			write_reg(CFG_SLEW_BASE + CFG_IDX_W'(i), pick_slew());
		for (i = 0; i < CHANNELS; i++)
			write_reg(CFG_OFFSET_BASE + CFG_IDX_W'(i), pick_offset());
	endtask

	// bursts of set commands followed by runs of ticks, with stray unused codes
	task automatic add_random_traffic(input int budget);
		int added;
		int sets;
		int ticks;
		int k;
		added = 0;
		while (added < budget) begin
			if ($urandom_range(0, 15) == 0)
				push_cmd(FUNC_UNUSED, 2'($urandom), LEVEL_W'($urandom));
			sets = $urandom_range(0, 3);
			for (k = 0; k < sets; k++) begin
				push_cmd(($urandom_range(0, 3) == 0) ? FUNC_SET_NOW : FUNC_SET_RAMP,
					2'($urandom), pick_level());
				added++;
			end
			ticks = $urandom_range(1, 24);
			for (k = 0; k < ticks; k++) begin
				push_cmd(FUNC_TICK, 2'($urandom), LEVEL_W'($urandom));
				added++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int i;
		int phase;
		for (i = 0; i < CHANNELS; i++) begin
			slew_len[i]   = 16'd1;
			offset_reg[i] = '0;
			target_lvl[i] = '0;
			level_now[i]  = '0;
			steps_left[i] = 16'd1;
			ramp_step[i]  = '0;
			ramp_acc[i]   = '0;
			ramping[i]    = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset state: first tick gives all-zero codes, the second nothing
		push_cmd(FUNC_TICK, 2'd0, '0);
		push_cmd(FUNC_TICK, 2'd3, LEVEL_MAX);
		push_cmd(FUNC_UNUSED, 2'd3, LEVEL_MAX);
		// sets never produce a frame, the following tick shows their effect
		push_cmd(FUNC_SET_NOW, 2'd0, LEVEL_MAX);
		push_cmd(FUNC_SET_RAMP, 2'd1, LEVEL_MAX);
		push_cmd(FUNC_SET_RAMP, 2'd2, '0);
		push_cmd(FUNC_SET_NOW, 2'd3, 14'h2AAA);
		push_cmd(FUNC_TICK, 2'd1, 14'h1555);
		push_cmd(FUNC_TICK, 2'd2, '0);
		wait_quiet();

		// zero slew length, longest slew, offsets at both ends
		write_reg(CFG_SLEW_BASE + 3'd0, 16'd0);
		write_reg(CFG_SLEW_BASE + 3'd1, 16'd1);
		write_reg(CFG_SLEW_BASE + 3'd2, 16'hFFFF);
		write_reg(CFG_SLEW_BASE + 3'd3, 16'd7);
		write_reg(CFG_OFFSET_BASE + 3'd0, 16'h3FFF);
		write_reg(CFG_OFFSET_BASE + 3'd1, 16'hC000);
		write_reg(CFG_OFFSET_BASE + 3'd2, 16'h8000);
		write_reg(CFG_OFFSET_BASE + 3'd3, 16'h7FFF);

		// reach the top exactly and clamp low, then restart a ramp part way and cut it short
		push_cmd(FUNC_SET_RAMP, 2'd0, '0);
		push_cmd(FUNC_SET_RAMP, 2'd1, LEVEL_MAX);
		push_cmd(FUNC_SET_RAMP, 2'd2, LEVEL_MAX);
		push_cmd(FUNC_SET_RAMP, 2'd3, 14'h1555);
		push_cmd(FUNC_TICK, 2'd0, '0);
		push_cmd(FUNC_TICK, 2'd0, '0);
		push_cmd(FUNC_TICK, 2'd0, '0);
		push_cmd(FUNC_SET_RAMP, 2'd3, LEVEL_MAX);
		push_cmd(FUNC_TICK, 2'd3, '0);
		push_cmd(FUNC_TICK, 2'd3, '0);
		push_cmd(FUNC_SET_NOW, 2'd3, 14'd1);
		push_cmd(FUNC_TICK, 2'd2, '0);
		push_cmd(FUNC_UNUSED, 2'd0, '0);
		push_cmd(FUNC_TICK, 2'd1, LEVEL_MAX);
		wait_quiet();

		// random phases, each under a fresh configuration; the last without idling
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 1)
				calm = 1'b1;
			set_random_config();
			add_random_traffic(135);
			wait_quiet();
		end

		if (error_count == 0 && expected_codes.size() == 0)
			$display("tb_quad_dac_slew_ramp_top OK");
		else
			$display("tb_quad_dac_slew_ramp_top NOT OK");
		$finish;
	end

endmodule
